>>> rtl/core/emef_pkg.sv
`default_nettype none
package emef_pkg;

	localparam int DUR_W  = 15;
	localparam int DIST_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam int ALPHA_W = 17;
	localparam int PROD_W = DIST_W + ALPHA_W;

	localparam logic [16:0] DIST_SCALE    = 17'd71932;
	localparam logic [16:0] ALPHA_DEFAULT = 17'd16384;
	localparam logic [16:0] ALPHA_ONE     = 17'd65536;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_OFFSET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 3'd4;

	typedef struct packed {
		logic [3:0]          sample_count;
		logic [DIST_W-1:0]   min_distance;
		logic [DIST_W-1:0]   max_distance;
		logic signed [15:0]  distance_offset;
		logic [ALPHA_W-1:0]  smoothing_factor;
	} cfg_t;

	typedef struct packed {
		logic load_dist;
		logic insert;
		logic calc_median;
		logic calc_prod;
		logic update_avg;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic batch_end;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/core/emef_cfg.sv
`default_nettype none
module emef_cfg
	import emef_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count     <= 4'd5;
			cfg_q.min_distance     <= '0;
			cfg_q.max_distance     <= '1;
			cfg_q.distance_offset  <= '0;
			cfg_q.smoothing_factor <= ALPHA_DEFAULT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SAMPLE_COUNT:     cfg_q.sample_count     <= cfg_data[3:0];
				REG_MIN_DISTANCE:     cfg_q.min_distance     <= cfg_data[15:0];
				REG_MAX_DISTANCE:     cfg_q.max_distance     <= cfg_data[15:0];
				REG_DISTANCE_OFFSET:  cfg_q.distance_offset  <= cfg_data[15:0];
				REG_SMOOTHING_FACTOR: cfg_q.smoothing_factor <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/core/emef_ctrl.sv
`default_nettype none
module emef_ctrl
	import emef_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_MEDIAN,
		ST_PROD,
		ST_AVG,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd             = '0;
		cmd.load_dist   = (state_q == ST_IDLE) && in_valid && !stall_q;
		cmd.insert      = (state_q == ST_INSERT);
		cmd.calc_median = (state_q == ST_MEDIAN);
		cmd.calc_prod   = (state_q == ST_PROD);
		cmd.update_avg  = (state_q == ST_AVG);
		cmd.load_out    = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stall_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !stall_q) begin
						state_q <= ST_INSERT;
						stall_q <= 1'b1;
					end
				end
				ST_INSERT: begin
					if (sts.batch_end) begin
						state_q <= ST_MEDIAN;
					end else begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_MEDIAN: state_q <= ST_PROD;
				ST_PROD:   state_q <= ST_AVG;
				ST_AVG:    state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						stall_q     <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall  = stall_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/core/emef_dpath.sv
`default_nettype none
module emef_dpath
	import emef_pkg::*;
#(
	parameter int MAX_SAMPLES = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic [DUR_W-1:0] echo_duration_us,
	output logic                  batch_used,
	output logic [DIST_W-1:0]     average_distance,
	output logic                  average_valid
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int LW = (CW > 4) ? CW : 4;

	logic [DIST_W-1:0] samples_q [MAX_SAMPLES];
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     pos_q;
	logic [DIST_W-1:0] avg_q;
	logic              seeded_q;

	logic [DIST_W-1:0] dist_s1;
	logic [DIST_W-1:0] med_q;
	logic              used_q;
	logic [PROD_W-1:0] prod_avg_q;
	logic [PROD_W-1:0] prod_med_q;

	logic              batch_used_q;
	logic [DIST_W-1:0] average_distance_q;
	logic              average_valid_q;

	logic [DUR_W+16:0]    dist_prod;
	logic                 keep;
	logic [MAX_SAMPLES-1:0] gt;
	logic [DIST_W-1:0]    ins_val [MAX_SAMPLES];
	logic [CW-1:0]        pos_inc;
	logic [LW-1:0]        batch_len;
	logic [IW-1:0]        mid_idx;
	logic [DIST_W-1:0]    med_raw;
	logic signed [17:0]   med_sum;
	logic [ALPHA_W-1:0]   alpha;
	logic [ALPHA_W-1:0]   weight;
	logic [PROD_W-1:0]    acc;

	assign dist_prod = (DUR_W + 17)'(echo_duration_us) * (DUR_W + 17)'(DIST_SCALE);

	always_ff @(posedge clk) begin
		if (cmd.load_dist) begin
			dist_s1 <= dist_prod[DIST_W+15:16];
		end
	end

	assign keep = (dist_s1 != '0) && (dist_s1 >= cfg.min_distance) &&
		(dist_s1 <= cfg.max_distance) && (cnt_q < CW'(MAX_SAMPLES));

	// sorted insert: each entry either keeps, takes the new value or shifts up
	always_comb begin
		for (int k = 0; k < MAX_SAMPLES; k++) begin
			gt[k] = (CW'(k) >= cnt_q) || (samples_q[k] > dist_s1);
		end
		for (int k = 0; k < MAX_SAMPLES; k++) begin
			if (!gt[k]) begin
				ins_val[k] = samples_q[k];
			end else if (k == 0) begin
				ins_val[k] = dist_s1;
			end else if (!gt[k-1]) begin
				ins_val[k] = dist_s1;
			end else begin
				ins_val[k] = samples_q[k-1];
			end
		end
	end

	for (genvar k = 0; k < MAX_SAMPLES; k++) begin : g_slot
		always_ff @(posedge clk) begin
			if (cmd.insert && keep && (CW'(k) <= cnt_q)) begin
				samples_q[k] <= ins_val[k];
			end
		end
	end

	assign pos_inc = pos_q + CW'(1);

	always_comb begin
		if (cfg.sample_count == '0) begin
			batch_len = LW'(1);
		end else if (LW'(cfg.sample_count) > LW'(MAX_SAMPLES)) begin
			batch_len = LW'(MAX_SAMPLES);
		end else begin
			batch_len = LW'(cfg.sample_count);
		end
	end

	assign sts.batch_end = LW'(pos_inc) >= batch_len;

	assign mid_idx = IW'(cnt_q >> 1);
	assign med_raw = samples_q[mid_idx];
	assign med_sum = $signed({2'b00, med_raw}) +
		$signed({{2{cfg.distance_offset[15]}}, cfg.distance_offset});

	always_comb begin
		if ((cfg.smoothing_factor == '0) || (cfg.smoothing_factor > ALPHA_ONE)) begin
			alpha = ALPHA_DEFAULT;
		end else begin
			alpha = cfg.smoothing_factor;
		end
		weight = ALPHA_ONE - alpha;
	end

	assign acc = prod_avg_q + prod_med_q + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (cmd.calc_median) begin
			used_q <= (cnt_q != '0) && (med_sum > 18'sd0);
			if (med_sum > 18'sd65535) begin
				med_q <= '1;
			end else begin
				med_q <= med_sum[DIST_W-1:0];
			end
		end
		if (cmd.calc_prod) begin
			prod_avg_q <= PROD_W'(avg_q) * PROD_W'(weight);
			prod_med_q <= PROD_W'(med_q) * PROD_W'(alpha);
		end
		if (cmd.load_out) begin
			batch_used_q       <= used_q;
			average_distance_q <= avg_q;
			average_valid_q    <= seeded_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pos_q    <= '0;
			avg_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				if (keep) begin
					cnt_q <= cnt_q + CW'(1);
				end
				pos_q <= sts.batch_end ? '0 : pos_inc;
			end
			if (cmd.calc_median) begin
				cnt_q <= '0;
			end
			if (cmd.update_avg && used_q) begin
				seeded_q <= 1'b1;
				avg_q    <= seeded_q ? acc[31:16] : med_q;
			end
		end
	end

	assign batch_used       = batch_used_q;
	assign average_distance = average_distance_q;
	assign average_valid    = average_valid_q;

endmodule
`default_nettype wire

>>> rtl/core/echo_median_ema_filter_core.sv
// echo median + moving average distance filter
//
// input channel (in_valid / in_stall, payload echo_duration_us): one echo
// duration in microseconds per request, 0 for a timeout. a request is taken
// when in_valid is high and in_stall low. after each request in_stall is high
// for one cycle while the distance is sorted into the batch store, so no new
// request is taken until that sort is done.
// the request that completes a batch keeps the input stalled through the sort,
// median pick with offset, product, average update and the result register,
// and longer while the result register is still held by out_stall. out_valid
// rises in the same cycle as in_stall falls.
// output channel (out_valid / out_stall): one request per batch with
// batch_used, average_distance and average_valid. the result register holds
// while out_stall is high; the next batch can be collected meanwhile, and a
// second finished batch waits in the controller until the register frees.
// configuration (cfg_wr_en, cfg_index, cfg_data) is to be written only while
// idle; the block itself does not enforce this. reset clears the batch, the
// average and the config to defaults; no request is taken until arst_n is released.
`default_nettype none
module echo_median_ema_filter_core
	import emef_pkg::*;
#(
	parameter int MAX_SAMPLES = 15
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [DUR_W-1:0]      echo_duration_us,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       batch_used,
	output logic [DIST_W-1:0]          average_distance,
	output logic                       average_valid
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	emef_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	emef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	emef_dpath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.sts              (sts),
		.echo_duration_us (echo_duration_us),
		.batch_used       (batch_used),
		.average_distance (average_distance),
		.average_valid    (average_valid)
	);

endmodule
`default_nettype wire

>>> rtl/core/emef_checker.sv
`default_nettype none
module emef_checker
	import emef_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic                  batch_used,
	input wire logic [DIST_W-1:0]     average_distance,
	input wire logic                  average_valid
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(average_distance) &&
		$stable(batch_used) && $stable(average_valid))
		else $error("stalled result changed");

	a_stall_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken without a sort cycle");

	a_used_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && batch_used |-> average_valid)
		else $error("used batch without a seeded average");

	a_unseeded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !average_valid |-> average_distance == '0)
		else $error("average nonzero before seeding");

endmodule

bind echo_median_ema_filter_core emef_checker u_emef_checker (.*);
`default_nettype wire
